// ===== hw/rtl/bda_pkg.sv =====
// Shared types, constants and helper functions of the bitmap descriptor allocator.
package bda_pkg;

  localparam int unsigned CNT_W   = 14;
  localparam int unsigned NUM_W   = 13;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DBYTE_W = CNT_W - 3;  // width of a byte count or byte index
  localparam int unsigned SEED_W  = 31;         // dividend width of the remainder unit

  localparam logic [TIME_W-1:0] LCG_MUL   = 32'd1103515245;
  localparam logic [TIME_W-1:0] LCG_INC   = 32'd12345;
  localparam logic [TIME_W-1:0] SEED_MASK = 32'h7fff_ffff;
  localparam logic [CNT_W-1:0]  CNT_RESET = 14'd8192;
  localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hff;
  localparam logic [BYTE_W-1:0] BIT_FIRST = 8'h80;

  localparam logic FUNC_ALLOC  = 1'b0;
  localparam logic FUNC_FREE   = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic                 start;
    logic [SEED_W-1:0]    dividend;
    logic [DBYTE_W-1:0]   divisor;
  } rem_req_t;

  typedef struct packed {
    logic                 done;
    logic [DBYTE_W-1:0]   rem;
  } rem_rsp_t;

  // Position of the first clear bit, counting from the most significant bit.
  function automatic logic [2:0] first_zero(input logic [BYTE_W-1:0] b);
    logic [2:0] pos;
    pos = '0;
    for (int k = 0; k < 8; k++) begin
      if (!b[k]) begin
        pos = 3'(7 - k);
      end
    end
    return pos;
  endfunction

  function automatic logic [BYTE_W-1:0] bit_mask(input logic [2:0] j);
    return BIT_FIRST >> j;
  endfunction

endpackage

// ===== hw/rtl/bda_intf.sv =====
// Handshake interfaces of the allocator: request, response and configuration channels.
interface bda_req_if;
  import bda_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [CNT_W-1:0]  dir_hint;
  logic [NUM_W-1:0]         free_number;
  logic [TIME_W-1:0]        current_time;

  modport source (output valid, func, dir_hint, free_number, current_time, input ready);
  modport sink   (input valid, func, dir_hint, free_number, current_time, output ready);
endinterface

interface bda_rsp_if;
  import bda_pkg::*;
  logic               valid;
  logic               ready;
  logic               status;
  logic [NUM_W-1:0]   alloc_number;
  logic [CNT_W-1:0]   free_count;

  modport source (output valid, status, alloc_number, free_count, input ready);
  modport sink   (input valid, status, alloc_number, free_count, output ready);
endinterface

interface bda_cfg_if;
  import bda_pkg::*;
  logic               valid;
  logic               ready;
  logic [CNT_W-1:0]   num_descriptors;

  modport source (output valid, num_descriptors, input ready);
  modport sink   (input valid, num_descriptors, output ready);
endinterface

// ===== hw/rtl/bitmap_descriptor_allocator.sv =====
// Top level of the bitmap descriptor allocator: control sequencer, bitmap RAM and remainder unit.
//
//   channel   dir  handshake            payload
//   cfg_if    in   valid/ready          num_descriptors (14b)
//   req_if    in   valid/ready          func, dir_hint (s14), free_number (13b), current_time (32b)
//   rsp_if    out  valid/ready          status, alloc_number (13b), free_count (14b)
//
// After reset the bitmap RAM is swept to zero, one byte per cycle; requests are held off
// during the sweep while configuration writes are always taken. A free steps through the
// accept with the RAM read, the write back and the result hand-off. An allocate gets its
// start byte from the remainder unit, then the scan reads one bitmap byte per cycle. A
// failed allocate scans every byte in use. An allocate with fewer than 8 numbers in use
// fails without a scan. Results sit in an output register, so a new request is taken while
// the previous result still waits; a stalled output holds only the finishing sequencer.
module bitmap_descriptor_allocator #(
  parameter int unsigned BITMAP_BYTES = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bda_cfg_if.sink    cfg_if,
  bda_req_if.sink    req_if,
  bda_rsp_if.source  rsp_if
);
  import bda_pkg::*;

  localparam int unsigned AW   = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  // Largest byte count the register can ask for, capped by the store size.
  localparam int unsigned DCAP = (BITMAP_BYTES < 2047) ? BITMAP_BYTES : 2047;
  localparam logic [DBYTE_W-1:0] DCAP_W = DBYTE_W'(DCAP);

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SEED,
    ST_DIV,
    ST_CHK,
    ST_FREE,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [CNT_W-1:0]    num_desc_q, num_desc_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [TIME_W-1:0]   prod_q, prod_d;
  logic                hint_neg_q, hint_neg_d;
  logic [9:0]          hint_byte_q, hint_byte_d;
  logic [NUM_W-1:0]    fnum_q, fnum_d;
  logic [DBYTE_W-1:0]  d_q, d_d;
  logic [DBYTE_W-1:0]  idx_q, idx_d;
  logic [DBYTE_W-1:0]  scan_n_q, scan_n_d;
  logic                res_status_q, res_status_d;
  logic [NUM_W-1:0]    res_num_q, res_num_d;
  logic                out_valid_q, out_valid_d;
  logic                out_status_q, out_status_d;
  logic [NUM_W-1:0]    out_num_q, out_num_d;
  logic [CNT_W-1:0]    out_cnt_q, out_cnt_d;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]   ram_wdata, ram_rdata;
  rem_req_t            rem_req;
  rem_rsp_t            rem_rsp;

  logic [DBYTE_W-1:0]  d_cfg;
  logic [DBYTE_W-1:0]  idx_nxt;
  logic [2:0]          zpos;
  logic [9:0]          free_byte;
  logic [TIME_W-1:0]   seed;

  // Byte count in use, saturated to the store size.
  assign d_cfg = (num_desc_q[CNT_W-1:3] > DCAP_W) ? DCAP_W : num_desc_q[CNT_W-1:3];
  assign idx_nxt   = (idx_q + 1'b1 == d_q) ? '0 : idx_q + 1'b1;
  assign zpos      = first_zero(ram_rdata);
  assign free_byte = req_if.free_number[NUM_W-1:3];
  assign seed      = (prod_q + LCG_INC) & SEED_MASK;

  assign req_if.ready = (state_q == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    num_desc_d   = num_desc_q;
    cnt_d        = cnt_q;
    prod_d       = prod_q;
    hint_neg_d   = hint_neg_q;
    hint_byte_d  = hint_byte_q;
    fnum_d       = fnum_q;
    d_d          = d_q;
    idx_d        = idx_q;
    scan_n_d     = scan_n_q;
    res_status_d = res_status_q;
    res_num_d    = res_num_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_num_d    = out_num_q;
    out_cnt_d    = out_cnt_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    rem_req      = '0;

    if (cfg_if.valid) begin
      num_desc_d = cfg_if.num_descriptors;
    end
    if (out_valid_q && rsp_if.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(BITMAP_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_if.valid) begin
          prod_d       = req_if.current_time * LCG_MUL;
          hint_neg_d   = req_if.dir_hint[CNT_W-1];
          hint_byte_d  = req_if.dir_hint[NUM_W-1:3];
          fnum_d       = req_if.free_number;
          d_d          = d_cfg;
          res_status_d = STATUS_OK;
          res_num_d    = '0;
          if (req_if.func == FUNC_FREE) begin
            cnt_d = cnt_q + 1'b1;
            // A number past the store still counts as freed but touches no bit.
            if (32'(free_byte) < BITMAP_BYTES) begin
              ram_re    = 1'b1;
              ram_raddr = AW'(free_byte);
              state_d   = ST_FREE;
            end else begin
              state_d = ST_DONE;
            end
          end else if (d_cfg == '0) begin
            res_status_d = STATUS_FULL;
            state_d      = ST_DONE;
          end else begin
            state_d = ST_SEED;
          end
        end
      end
      ST_SEED: begin
        rem_req.start    = 1'b1;
        rem_req.dividend = hint_neg_q ? seed[SEED_W-1:0] : SEED_W'(hint_byte_q);
        rem_req.divisor  = d_q;
        state_d          = ST_DIV;
      end
      ST_DIV: begin
        if (rem_rsp.done) begin
          idx_d     = rem_rsp.rem;
          scan_n_d  = '0;
          ram_re    = 1'b1;
          ram_raddr = AW'(rem_rsp.rem);
          state_d   = ST_CHK;
        end
      end
      ST_CHK: begin
        if (ram_rdata != BYTE_FULL) begin
          ram_we       = 1'b1;
          ram_waddr    = AW'(idx_q);
          ram_wdata    = ram_rdata | bit_mask(zpos);
          cnt_d        = cnt_q - 1'b1;
          res_num_d    = NUM_W'({idx_q, zpos});
          state_d      = ST_DONE;
        end else if (scan_n_q + 1'b1 == d_q) begin
          res_status_d = STATUS_FULL;
          state_d      = ST_DONE;
        end else begin
          // Fetch the next byte while this one is judged full.
          idx_d     = idx_nxt;
          scan_n_d  = scan_n_q + 1'b1;
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_nxt);
        end
      end
      ST_FREE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(fnum_q[NUM_W-1:3]);
        ram_wdata = ram_rdata & ~bit_mask(fnum_q[2:0]);
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_if.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_num_d    = res_num_q;
          out_cnt_d    = cnt_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      clr_q        <= '0;
      num_desc_q   <= CNT_RESET;
      cnt_q        <= CNT_RESET;
      prod_q       <= '0;
      hint_neg_q   <= 1'b0;
      hint_byte_q  <= '0;
      fnum_q       <= '0;
      d_q          <= '0;
      idx_q        <= '0;
      scan_n_q     <= '0;
      res_status_q <= STATUS_OK;
      res_num_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STATUS_OK;
      out_num_q    <= '0;
      out_cnt_q    <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      num_desc_q   <= num_desc_d;
      cnt_q        <= cnt_d;
      prod_q       <= prod_d;
      hint_neg_q   <= hint_neg_d;
      hint_byte_q  <= hint_byte_d;
      fnum_q       <= fnum_d;
      d_q          <= d_d;
      idx_q        <= idx_d;
      scan_n_q     <= scan_n_d;
      res_status_q <= res_status_d;
      res_num_q    <= res_num_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_num_q    <= out_num_d;
      out_cnt_q    <= out_cnt_d;
    end
  end

  assign rsp_if.valid        = out_valid_q;
  assign rsp_if.status       = out_status_q;
  assign rsp_if.alloc_number = out_num_q;
  assign rsp_if.free_count   = out_cnt_q;

  bda_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BITMAP_BYTES)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bda_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  a_alloc_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK) && ram_we |-> $countones(ram_wdata ^ ram_rdata) == 1)
    else $error("allocate changed other than one bit");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK) |-> (scan_n_q < d_q) && (idx_q < d_q))
    else $error("scan ran past the byte count");
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_if.valid && req_if.ready |=> state_q != ST_IDLE)
    else $error("accepted item left no work");

endmodule

// ===== hw/rtl/bda_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module bda_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bda_rem.sv =====
// Restoring remainder unit: one quotient bit per cycle over the whole SEED_W-bit dividend.
module bda_rem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bda_pkg::rem_req_t  req_i,
  output bda_pkg::rem_rsp_t  rsp_o
);
  import bda_pkg::*;

  localparam int unsigned STEP_W = $clog2(SEED_W + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [SEED_W-1:0]   quo_q, quo_d;
  logic [DBYTE_W-1:0]  rem_q, rem_d;
  logic [DBYTE_W-1:0]  div_q, div_d;
  logic [DBYTE_W:0]    trial;
  logic [DBYTE_W:0]    diff;

  always_comb begin
    trial  = {rem_q, quo_q[SEED_W-1]};
    diff   = trial - {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      // Subtract the divisor whenever the partial remainder reaches it.
      rem_d  = (trial >= {1'b0, div_q}) ? diff[DBYTE_W-1:0] : trial[DBYTE_W-1:0];
      quo_d  = {quo_q[SEED_W-2:0], 1'b0};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(SEED_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      div_q  <= div_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < div_q) else $error("remainder not below divisor");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("start did not make the unit busy");
  a_div_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start |=> $stable(div_q)) else $error("divisor changed mid operation");

endmodule

// ===== test/tb_bitmap_descriptor_allocator.sv =====
`timescale 1ns / 1ps
// Testbench of the bitmap descriptor allocator: directed and random requests against a bitmap predictor.
module tb_bitmap_descriptor_allocator;
  import bda_pkg::*;

  // The block is built with the default store of 1024 bytes, one bit per number.
  localparam int unsigned MAP_BYTES    = 1024;
  // Longest idle that either side draws before an item.
  localparam int unsigned MAX_WAIT     = 18;
  // The one long receiver hold-off, long enough for the block to fill up and stall its input.
  localparam int unsigned LONG_HOLD    = 400;
  // Cycles without any handshake before the run is declared hung. The slowest correct
  // stretch is the clearing sweep after reset or a full-map allocate plus the long
  // hold-off and the longest idle, so this is several times over.
  localparam int unsigned STALL_LIMIT  = 8000;
  // Cycles to watch for stray results once every expectation has been met.
  localparam int unsigned DRAIN_CYCLES = 64;
  // Idle time before a register write; every item causes a result, so little is needed.
  localparam int unsigned CFG_SETTLE   = 8;
  localparam int unsigned MAX_REPORTS  = 40;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_HALF   = 31;

  typedef struct packed {
    logic                     func;
    logic signed [CNT_W-1:0]  hint;
    logic [NUM_W-1:0]         fnum;
    logic [TIME_W-1:0]        now;
  } request_t;

  typedef struct packed {
    logic               status;
    logic [NUM_W-1:0]   number;
    logic [CNT_W-1:0]   count;
  } outcome_t;

  typedef struct packed {
    request_t req;
    outcome_t outcome;
  } job_t;

  logic clk_i;
  logic rst_ni;

  bda_cfg_if cfg_if ();
  bda_req_if req_if ();
  bda_rsp_if rsp_if ();

  bitmap_descriptor_allocator #(
    .BITMAP_BYTES(MAP_BYTES)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .cfg_if(cfg_if),
    .req_if(req_if),
    .rsp_if(rsp_if)
  );

  // Shadow copy of the block's state and of its one register. The outcome of each
  // request is worked out when the request is queued; since requests are taken in
  // order and the register only changes while the block is idle, the shadow state at
  // that point is exactly the state the block will see when it takes the item.
  logic [BYTE_W-1:0] shadow_map [MAP_BYTES];
  logic [CNT_W-1:0]  shadow_free;
  logic [CNT_W-1:0]  shadow_ndesc;

  // Numbers handed out by successful allocates and not yet given back on purpose.
  logic [NUM_W-1:0] held_numbers [$];
  // Items waiting to be offered, each with its predicted outcome.
  job_t request_backlog [$];
  // Outcomes of items the block has taken, oldest first.
  outcome_t expected_outcomes [$];
  outcome_t in_flight;

  int unsigned jobs_open;     // queued items whose result has not been checked yet
  int unsigned mismatches;
  int unsigned send_gap;
  int unsigned rsp_wait;
  int unsigned idle_cycles;
  int unsigned holds_asked;
  int unsigned holds_done;
  bit          calm;          // when set, neither side draws an idle

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Predicts one request and updates the shadow state. A free clears the bit without
  // checking that it was set; an allocate scans from its start byte with wraparound for a
  // byte that is not all ones and takes its first clear bit, most significant bit first.
  function automatic outcome_t predict_outcome(input request_t r);
    outcome_t          o;
    int unsigned       nbytes;
    int unsigned       start;
    int unsigned       idx;
    int unsigned       pos;
    int unsigned       n;
    logic [TIME_W-1:0] seed;
    bit                found;
    o.status = STATUS_OK;
    o.number = '0;
    found    = 1'b0;
    if (r.func == FUNC_FREE) begin
      shadow_free = shadow_free + 1'b1;
      idx = 32'(r.fnum >> 3);
      if (idx < MAP_BYTES) begin
        shadow_map[idx] = shadow_map[idx] & ~(BIT_FIRST >> r.fnum[2:0]);
      end
    end else begin
      // The byte count saturates at the size of the store.
      nbytes = 32'(shadow_ndesc >> 3);
      if (nbytes > MAP_BYTES) begin
        nbytes = MAP_BYTES;
      end
      if (nbytes == 0) begin
        o.status = STATUS_FULL;
      end else begin
        if (r.hint[CNT_W-1]) begin
          // Any negative hint selects the start derived from the time.
          seed  = r.now * LCG_MUL + LCG_INC;
          seed  = seed & SEED_MASK;
          start = seed % nbytes;
        end else begin
          start = 32'(r.hint[NUM_W-1:3]) % nbytes;
        end
        idx = start;
        for (n = 0; n < nbytes && !found; n++) begin
          if (shadow_map[idx] != BYTE_FULL) begin
            found = 1'b1;
          end else begin
            idx = (idx + 1 == nbytes) ? 0 : idx + 1;
          end
        end
        if (!found) begin
          o.status = STATUS_FULL;
        end else begin
          pos = 0;
          while (shadow_map[idx][7 - pos]) begin
            pos++;
          end
          shadow_map[idx] = shadow_map[idx] | (BIT_FIRST >> pos);
          shadow_free     = shadow_free - 1'b1;
          o.number        = NUM_W'(idx * 8 + pos);
        end
      end
    end
    o.count = shadow_free;
    return o;
  endfunction

  function automatic int unsigned draw_wait();
    if (calm || $urandom_range(3) == 0) begin
      return 0;
    end
    return $urandom_range(MAX_WAIT);
  endfunction

  // Hints: the time-based start, other negative values, anywhere in the number range,
  // and mostly near the numbers in use so that in-range starts dominate.
  function automatic logic signed [CNT_W-1:0] draw_hint();
    int unsigned      pick;
    logic [NUM_W-1:0] near;
    pick = $urandom_range(99);
    near = NUM_W'($urandom());
    if (shadow_ndesc >= 8 && shadow_ndesc <= CNT_RESET) begin
      near = NUM_W'($urandom_range(shadow_ndesc - 1));
    end
    if (pick < 25) begin
      return '1;
    end
    if (pick < 35) begin
      return {1'b1, NUM_W'($urandom())};
    end
    if (pick < 50) begin
      return {1'b0, NUM_W'($urandom())};
    end
    return {1'b0, near};
  endfunction

  task automatic queue_request(input logic func, input logic signed [CNT_W-1:0] hint,
                               input logic [NUM_W-1:0] fnum, input logic [TIME_W-1:0] now);
    job_t j;
    j.req.func  = func;
    j.req.hint  = hint;
    j.req.fnum  = fnum;
    j.req.now   = now;
    j.outcome   = predict_outcome(j.req);
    if (func == FUNC_ALLOC && j.outcome.status == STATUS_OK) begin
      held_numbers.push_back(j.outcome.number);
    end
    jobs_open++;
    request_backlog.push_back(j);
  endtask

  task automatic alloc_near(input logic signed [CNT_W-1:0] hint, input logic [TIME_W-1:0] now);
    queue_request(FUNC_ALLOC, hint, NUM_W'($urandom()), now);
  endtask

  task automatic release_number(input logic [NUM_W-1:0] num);
    queue_request(FUNC_FREE, draw_hint(), num, $urandom());
  endtask

  // Gives back one number that is still held, picked at random.
  task automatic release_held();
    int unsigned k;
    logic [NUM_W-1:0] num;
    k   = $urandom_range(held_numbers.size() - 1);
    num = held_numbers[k];
    held_numbers.delete(k);
    release_number(num);
  endtask

  task automatic wait_all_answered();
    while (jobs_open != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Writes the descriptor count once the block is idle and mirrors it in the shadow.
  task automatic write_ndesc(input logic [CNT_W-1:0] value);
    wait_all_answered();
    repeat (CFG_SETTLE) @(posedge clk_i);
    cfg_if.num_descriptors <= value;
    cfg_if.valid           <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    shadow_ndesc = value;
  endtask

  // Mostly well-formed traffic: allocates, and frees of numbers that were handed out.
  // A small share frees arbitrary numbers, which may be double frees.
  task automatic random_traffic(input int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        release_number(NUM_W'($urandom()));
      end else if (pick < 45 && held_numbers.size() != 0) begin
        release_held();
      end else begin
        alloc_near(draw_hint(), $urandom());
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatches < MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
    mismatches++;
  endtask

  // Sender: offers the backlog in order, with a drawn idle before each item. An item
  // stays on the channel until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin : tx_side
    job_t next_job;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      send_gap     <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_outcomes.push_back(in_flight);
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          next_job            = request_backlog.pop_front();
          req_if.func         <= next_job.req.func;
          req_if.dir_hint     <= next_job.req.hint;
          req_if.free_number  <= next_job.req.fnum;
          req_if.current_time <= next_job.req.now;
          req_if.valid        <= 1'b1;
          in_flight           <= next_job.outcome;
          send_gap            <= draw_wait();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result against the oldest expectation, then holds ready low
  // for a drawn number of cycles, or for the long hold-off when one has been asked for.
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    outcome_t    want;
    int unsigned hold;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_wait     <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected result, alloc_number", '0, 32'(rsp_if.alloc_number));
      end else begin
        want = expected_outcomes.pop_front();
        jobs_open--;
        if (rsp_if.status !== want.status) begin
          report_mismatch("status", 32'(want.status), 32'(rsp_if.status));
        end
        if (rsp_if.alloc_number !== want.number) begin
          report_mismatch("alloc_number", 32'(want.number), 32'(rsp_if.alloc_number));
        end
        if (rsp_if.free_count !== want.count) begin
          report_mismatch("free_count", 32'(want.count), 32'(rsp_if.free_count));
        end
      end
      hold = draw_wait();
      if (holds_asked != holds_done) begin
        hold = LONG_HOLD;
        holds_done++;
      end
      rsp_wait     <= hold;
      rsp_if.ready <= (hold == 0);
    end else if (rsp_wait != 0) begin
      rsp_wait     <= rsp_wait - 1;
      rsp_if.ready <= (rsp_wait == 1);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Watchdog: ends the run when no channel moves an item for too long.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CNT_W-1:0] phase_ndesc [RAND_PHASES];
    // Every input known from the start; reset is asserted here and released once.
    rst_ni                 = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.num_descriptors = '0;
    req_if.valid           = 1'b0;
    req_if.func            = FUNC_ALLOC;
    req_if.dir_hint        = '0;
    req_if.free_number     = '0;
    req_if.current_time    = '0;
    rsp_if.ready           = 1'b0;
    jobs_open              = 0;
    mismatches             = 0;
    idle_cycles            = 0;
    holds_asked            = 0;
    holds_done             = 0;
    calm                   = 1'b0;
    shadow_free            = CNT_RESET;
    shadow_ndesc           = CNT_RESET;
    foreach (shadow_map[k]) begin
      shadow_map[k] = '0;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with the reset setting of 1024 bytes in use.
    // Time-based start at both ends of the time field.
    alloc_near(CNT_W'(-1), 32'h0000_0000);
    alloc_near(CNT_W'(-1), 32'hffff_ffff);
    // Hints at the top and bottom of the number range.
    alloc_near(CNT_W'(8191), 32'h0000_0000);
    alloc_near(CNT_W'(8191), 32'h0000_0000);
    alloc_near(CNT_W'(0), 32'hffff_ffff);
    // A negative hint other than -1 also selects the time-based start.
    alloc_near(CNT_W'(-8192), 32'h8000_0000);
    alloc_near(CNT_W'(-2), 32'h5555_5555);
    // Frees need no prior allocate; a number that came back is handed out again.
    release_number(NUM_W'(8184));
    release_number(13'h1fff);
    release_number(NUM_W'(0));
    alloc_near(CNT_W'(8184), 32'haaaa_aaaa);

    // A register value above the store size saturates to the whole store.
    write_ndesc('1);
    alloc_near(CNT_W'(8191), 32'h0000_0000);

    // Fewer than eight numbers in use: allocates fail, frees still count.
    write_ndesc(CNT_W'(0));
    alloc_near(CNT_W'(-1), 32'h0000_0007);
    release_number(NUM_W'(5));

    // A single byte in use: fill it until the map is full, then reuse a freed number.
    // The out-of-range hint is reduced into the one byte.
    write_ndesc(CNT_W'(8));
    repeat (9) alloc_near(CNT_W'(8191), $urandom());
    release_number(NUM_W'(3));
    alloc_near(CNT_W'(-1), $urandom());

    // Twelve bytes, a count that is not a multiple of eight; the top hint wraps into range.
    write_ndesc(CNT_W'(100));
    alloc_near(CNT_W'(8191), 32'h0000_0000);
    alloc_near(CNT_W'(95), 32'h0000_0000);

    // Random phases, each under its own setting; small maps fill up and fail often.
    phase_ndesc[0] = CNT_W'(16);
    phase_ndesc[1] = CNT_W'(24);
    phase_ndesc[2] = CNT_W'(64);
    phase_ndesc[3] = CNT_W'(8191);
    phase_ndesc[4] = CNT_RESET;
    phase_ndesc[5] = '1;
    phase_ndesc[6] = CNT_W'($urandom_range(255, 8));
    phase_ndesc[7] = CNT_W'($urandom());
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_ndesc(phase_ndesc[p]);
      if (p == 2) begin
        // The receiver holds off for a long stretch while the sender keeps offering
        // back to back, so the output register fills and the input stalls.
        calm = 1'b1;
        holds_asked++;
        random_traffic(24);
        wait_all_answered();
        calm = 1'b0;
      end
      random_traffic(PHASE_HALF);
      // The sender pauses until every result of the phase so far has come.
      wait_all_answered();
      random_traffic(PHASE_HALF);
    end

    wait_all_answered();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== bitmap_descriptor_allocator.f =====
hw/rtl/bda_pkg.sv
hw/rtl/bda_intf.sv
hw/rtl/bda_ram.sv
hw/rtl/bda_rem.sv
hw/rtl/bitmap_descriptor_allocator.sv
test/tb_bitmap_descriptor_allocator.sv
